[rtl/dfr_pkg.sv]
package dfr_pkg;

    // Configuration register indexes (byte address is 4 * index).
    localparam logic [1:0] REG_OPEN_BYTE     = 2'd0;
    localparam logic [1:0] REG_CLOSE_BYTE    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [7:0]  OPEN_BYTE_RST     = 8'd60;
    localparam logic [7:0]  CLOSE_BYTE_RST    = 8'd62;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd100;

    // The terminator that closes every message.
    localparam logic [7:0] TERM_BYTE = 8'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an rx item is taken this cycle
        logic load_data;  // load the stored byte at the read pointer into the output
        logic load_term;  // load the terminator and clear the frame
    } dfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_emit; // the item on the rx channel closes an open frame
        logic rd_done;    // every stored byte has been sent
    } dfr_status_t;

endpackage

[rtl/dfr_ram.sv]
module dfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dfr_datapath.sv]
module dfr_datapath #(
    parameter int unsigned MAX_FRAME_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [dfr_pkg::PDATA_W-1:0]   prdata,
    // Input item fields.
    input  logic [7:0]                    rx_byte,
    input  logic [31:0]                   now_tick,
    // Result item fields.
    output logic [7:0]                    msg_byte,
    output logic                          msg_last,
    // Controller link.
    input  dfr_pkg::dfr_cmd_t             cmd,
    output dfr_pkg::dfr_status_t          status
);

    import dfr_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_FRAME_LEN);
    localparam int unsigned CNT_W  = $clog2(MAX_FRAME_LEN + 1);

    logic [7:0]        open_byte_reg;
    logic [7:0]        close_byte_reg;
    logic [31:0]       timeout_ticks_reg;

    logic [31:0]       prev_tick_reg;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [7:0]        msg_byte_reg;
    logic              msg_last_reg;

    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [31:0]       tick_gap;
    logic              timed_out;
    logic              in_frame_eff;
    logic [CNT_W-1:0]  fill_eff;
    logic [CNT_W-1:0]  fill_inc;
    logic              is_open;
    logic              is_close;
    logic              store_we;
    logic [7:0]        store_rdata;

    // Configuration registers.
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_byte_reg     <= OPEN_BYTE_RST;
            close_byte_reg    <= CLOSE_BYTE_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OPEN_BYTE:     open_byte_reg     <= pwdata[7:0];
                REG_CLOSE_BYTE:    close_byte_reg    <= pwdata[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_OPEN_BYTE:     prdata = {24'd0, open_byte_reg};
            REG_CLOSE_BYTE:    prdata = {24'd0, close_byte_reg};
            REG_TIMEOUT_TICKS: prdata = timeout_ticks_reg;
            default:           prdata = '0;
        endcase
    end

    // Frame decode for the item on the rx channel.
    assign tick_gap     = now_tick - prev_tick_reg;
    assign timed_out    = tick_gap > timeout_ticks_reg;
    assign in_frame_eff = in_frame_reg && !timed_out;
    assign fill_eff     = timed_out ? '0 : fill_count_reg;
    assign fill_inc     = fill_eff + CNT_W'(1);
    assign is_open      = rx_byte == open_byte_reg;
    assign is_close     = rx_byte == close_byte_reg;

    assign status.start_emit = !is_open && is_close && in_frame_eff;
    assign status.rd_done    = CNT_W'(rd_ptr_reg) == fill_count_reg;

    assign store_we = cmd.accept && !is_open && !is_close && in_frame_eff;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        fill_count_next = fill_count_reg;
        if (cmd.accept)
        begin
            priority if (is_open)
            begin
                in_frame_next   = 1'b1;
                fill_count_next = '0;
            end
            else if (status.start_emit)
            begin
                // The count is kept until the terminator has been loaded.
                in_frame_next   = 1'b0;
                fill_count_next = fill_eff;
            end
            else if (in_frame_eff)
            begin
                if (fill_inc == CNT_W'(MAX_FRAME_LEN))
                begin
                    in_frame_next   = 1'b0;
                    fill_count_next = '0;
                end
                else
                begin
                    in_frame_next   = 1'b1;
                    fill_count_next = fill_inc;
                end
            end
            else
            begin
                in_frame_next   = 1'b0;
                fill_count_next = '0;
            end
        end
        else if (cmd.load_term)
        begin
            fill_count_next = '0;
        end
    end

    // The read address runs one step ahead so the RAM output is ready in time.
    always_comb
    begin
        priority if (cmd.accept)
        begin
            rd_ptr_next = '0;
        end
        else if (cmd.load_data)
        begin
            rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tick_reg  <= '0;
            in_frame_reg   <= 1'b0;
            fill_count_reg <= '0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                prev_tick_reg <= now_tick;
            end
            in_frame_reg   <= in_frame_next;
            fill_count_reg <= fill_count_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    dfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (fill_eff[ADDR_W-1:0]),
        .wdata (rx_byte),
        .raddr (rd_ptr_next),
        .rdata (store_rdata)
    );

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
        begin
            msg_byte_reg <= store_rdata;
            msg_last_reg <= 1'b0;
        end
        else if (cmd.load_term)
        begin
            msg_byte_reg <= TERM_BYTE;
            msg_last_reg <= 1'b1;
        end
    end

    assign msg_byte = msg_byte_reg;
    assign msg_last = msg_last_reg;

endmodule

[rtl/dfr_ctrl.sv]
module dfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    output logic                 msg_valid,
    input  logic                 msg_stall,
    input  dfr_pkg::dfr_status_t status,
    output dfr_pkg::dfr_cmd_t    cmd
);

    import dfr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   msg_valid_reg;
    logic   msg_valid_next;
    logic   slot_free;

    assign slot_free = !msg_valid_reg || !msg_stall;
    assign rx_stall  = state_reg == ST_EMIT;
    assign msg_valid = msg_valid_reg;

    always_comb
    begin
        cmd.accept    = rx_valid && (state_reg == ST_IDLE);
        cmd.load_data = (state_reg == ST_EMIT) && slot_free && !status.rd_done;
        cmd.load_term = (state_reg == ST_EMIT) && slot_free && status.rd_done;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.start_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.load_term)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        priority if (cmd.load_data || cmd.load_term)
        begin
            msg_valid_next = 1'b1;
        end
        else if (!msg_stall)
        begin
            msg_valid_next = 1'b0;
        end
        else
        begin
            msg_valid_next = msg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            msg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msg_valid_reg <= msg_valid_next;
        end
    end

endmodule

[rtl/delimited_frame_receiver_top.sv]
// Delimited frame receiver with an inter-byte timeout.
// Received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte, now_tick), one item
// per byte together with the tick at which it arrived. Bytes between an open byte and a
// close byte are collected in a frame store; the close byte sends them out on the msg
// channel (msg_valid, msg_stall, msg_byte, msg_last), followed by a zero terminator that
// carries msg_last. A tick gap larger than timeout_ticks drops a partial frame, and a frame
// that fills MAX_FRAME_LEN entries is dropped as well.
// An item that does not close a frame is taken whenever the block is idle, so such items may
// arrive back to back. A closing item holds off the rx channel while its N stored bytes (N is
// at most MAX_FRAME_LEN - 1) and the terminator are sent: the frame store is a
// single-port-read RAM read one entry a cycle while msg_stall does not hold the output.
// While the message drains, rx_stall is high; a stall on msg_stall holds the output
// register and pauses the drain, and a waiting result does not keep the next rx item out.
// The user must write the configuration port (open_byte, close_byte, timeout_ticks at byte
// addresses 0, 4, 8) only while the block is idle; the block does not enforce it. Reset
// clears the frame state, the tick history and the registers to their defaults; the frame
// store needs no clearing, since only entries written in the current frame are ever read.
module delimited_frame_receiver_top #(
    parameter int unsigned MAX_FRAME_LEN = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfr_pkg::PADDR_W-1:0] paddr,
    input  logic [dfr_pkg::PDATA_W-1:0] pwdata,
    output logic [dfr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [7:0]                  rx_byte,
    input  logic [31:0]                 now_tick,
    output logic                        msg_valid,
    input  logic                        msg_stall,
    output logic [7:0]                  msg_byte,
    output logic                        msg_last
);

    import dfr_pkg::*;

    dfr_cmd_t    cmd;
    dfr_status_t status;

    // The register file always answers in the access cycle.
    assign pready = 1'b1;

    dfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dfr_datapath #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .rx_byte  (rx_byte),
        .now_tick (now_tick),
        .msg_byte (msg_byte),
        .msg_last (msg_last),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef NO_ASSERTIONS
    // A closing item must hold off the rx channel while its message drains.
    a_close_stalls_rx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && status.start_emit |=> rx_stall)
        else $error("closing item did not stall the rx channel");

    // The terminator always goes out as a zero byte marked last.
    a_term_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_term |=> msg_valid && msg_last && (msg_byte == TERM_BYTE) && !rx_stall)
        else $error("terminator not presented correctly");

    // Taking input and loading the output never happen in the same cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load_data, cmd.load_term}))
        else $error("conflicting controller commands");
`endif

endmodule
